[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of the word list block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is high.
`define MTF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also runs through reset.
`define MTF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/mtf_pkg.sv]
// Shared types and constants of the move-to-front word list.
// No dependencies.
`default_nettype none

package mtf_pkg;

   localparam int WORD_W = 64;
   localparam int KIND_W = 2;

   localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_LIST = 1'b1;

   // One queued command, key already normalized.
   typedef struct packed {
      logic              op;
      logic [WORD_W-1:0] word;
   } cmd_type;

   // Front-to-back command handshake.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_chan_type;

endpackage

`default_nettype wire

[hw/rtl/move_to_front_word_list.sv]
// Move-to-front word list: an add is popped from the queue, then shifted in and acked.
// A list item takes one pop, one beat per entry and one end beat on the back end.
// The back-end sequencer is the rate limit; a two-deep queue lets the front keep accepting.
// Synchronous active-high reset clears the count, queue fill and control; words are not cleared.
// Depends on mtf_pkg, mtf_front and mtf_back.
`default_nettype none

module move_to_front_word_list
   import mtf_pkg::*;
#(
   parameter int MAX_WORDS  = 5,
   parameter int WORD_BYTES = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_op,
   input  wire logic [WORD_W-1:0] req_word_key,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [KIND_W-1:0]      rsp_kind,
   output logic [WORD_W-1:0]      rsp_entry_word,
   output logic                   rsp_last
);

   // Normalized commands flow from the front queue to the back sequencer.
   cmd_chan_type cmd_chan;
   logic         cmd_pop;

   // Front: take request beats whenever the queue has room, trim keys on the way in.
   mtf_front #(
      .WORD_BYTES(WORD_BYTES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_word_key (req_word_key),
      .cmd_chan     (cmd_chan),
      .cmd_pop      (cmd_pop)
   );

   // Back: search and shift on adds, rotate entries out on lists, drive the
   // registered response beat; a stalled consumer holds the back and so fills the queue.
   mtf_back #(
      .MAX_WORDS(MAX_WORDS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_chan       (cmd_chan),
      .cmd_pop        (cmd_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_entry_word (rsp_entry_word),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

[hw/rtl/mtf_front.sv]
// Front part: accepts request beats, normalizes the key, holds them in a two-deep queue.
// Depends on mtf_pkg.
`default_nettype none

module mtf_front
   import mtf_pkg::*;
#(
   parameter int WORD_BYTES = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_op,
   input  wire logic [WORD_W-1:0] req_word_key,
   output cmd_chan_type           cmd_chan,
   input  wire logic              cmd_pop
);

   cmd_type     slot0_ff, slot0_in;
   cmd_type     slot1_ff, slot1_in;
   logic [1:0]  fill_ff, fill_in;
   logic [1:0]  fill_mid;
   logic        push;
   logic        pop;
   cmd_type     new_cmd;

   // Cut the key at its first zero byte and at WORD_BYTES.
   always_comb begin
      logic alive;
      alive = 1'b1;
      new_cmd.op   = req_op;
      new_cmd.word = '0;
      for (int b = 0; b < 8; b++) begin
         alive = alive && (b < WORD_BYTES) && (req_word_key[8*b +: 8] != 8'h00);
         if (alive) begin
            new_cmd.word[8*b +: 8] = req_word_key[8*b +: 8];
         end
      end
   end

   assign req_ready = (fill_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign pop       = cmd_pop && (fill_ff != 2'd0);
   assign fill_mid  = fill_ff - {1'b0, pop};

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (pop) begin
         slot0_in = slot1_ff;
      end
      if (push) begin
         if (fill_mid == 2'd0) begin
            slot0_in = new_cmd;
         end else begin
            slot1_in = new_cmd;
         end
      end
      fill_in = fill_mid + {1'b0, push};
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      if (reset) begin
         fill_ff <= 2'd0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assign cmd_chan.valid = (fill_ff != 2'd0);
   assign cmd_chan.cmd   = slot0_ff;

endmodule

`default_nettype wire

[hw/rtl/mtf_back.sv]
// Back part: recency list storage, search-and-shift for adds, rotate-out for listing.
// Depends on mtf_pkg.
`default_nettype none

module mtf_back
   import mtf_pkg::*;
#(
   parameter int MAX_WORDS = 5
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_chan_type      cmd_chan,
   output logic                   cmd_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [KIND_W-1:0]      rsp_kind,
   output logic [WORD_W-1:0]      rsp_entry_word,
   output logic                   rsp_last
);

   localparam int CW = $clog2(MAX_WORDS + 1);
   localparam logic [CW-1:0] CAP_C = CW'(MAX_WORDS);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SHIFT = 3'b010,
      ST_LIST  = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     step_ff, step_in;
   logic [MAX_WORDS-1:0] hit_ff, hit_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [WORD_W-1:0] entries_ff [MAX_WORDS];
   logic [WORD_W-1:0] entries_in [MAX_WORDS];
   logic [WORD_W-1:0] nxt_entry  [MAX_WORDS];
   logic [WORD_W-1:0] prv_entry  [MAX_WORDS];

   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [WORD_W-1:0] rsp_word_ff, rsp_word_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              out_free;
   logic              found;

   // Neighbor taps: next wraps to the front, previous of the front is the new word.
   for (genvar g = 0; g < MAX_WORDS; g++) begin : g_taps
      if (g < MAX_WORDS - 1) begin : g_nxt
         assign nxt_entry[g] = entries_ff[g+1];
      end else begin : g_wrap
         assign nxt_entry[g] = entries_ff[0];
      end
      if (g > 0) begin : g_prv
         assign prv_entry[g] = entries_ff[g-1];
      end else begin : g_head
         assign prv_entry[g] = word_ff;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign found    = |hit_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      hit_in       = hit_ff;
      word_in      = word_ff;
      entries_in   = entries_ff;
      cmd_pop      = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_chan.valid) begin
               cmd_pop = 1'b1;
               word_in = cmd_chan.cmd.word;
               for (int i = 0; i < MAX_WORDS; i++) begin
                  hit_in[i] = (entries_ff[i] == cmd_chan.cmd.word) && (CW'(i) < count_ff);
               end
               if (cmd_chan.cmd.op == OP_LIST) begin
                  step_in  = '0;
                  state_in = ST_LIST;
               end else begin
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            if (out_free) begin
               if (word_ff != '0) begin
                  for (int i = 0; i < MAX_WORDS; i++) begin
                     if (i == 0) begin
                        entries_in[i] = prv_entry[i];
                     end else if (found ? |(hit_ff >> i) : (CW'(i) <= count_ff)) begin
                        entries_in[i] = prv_entry[i];
                     end
                  end
                  if (!found && (count_ff < CAP_C)) begin
                     count_in = count_ff + 1'b1;
                  end
               end
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_ACK;
               rsp_word_in  = '0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_LIST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (step_ff < count_ff) begin
                  // Emit the front, rotate the live entries by one.
                  rsp_kind_in = KIND_ENTRY;
                  rsp_word_in = entries_ff[0];
                  rsp_last_in = 1'b0;
                  for (int i = 0; i < MAX_WORDS; i++) begin
                     if (CW'(i + 1) == count_ff) begin
                        entries_in[i] = entries_ff[0];
                     end else if (CW'(i) < count_ff) begin
                        entries_in[i] = nxt_entry[i];
                     end
                  end
                  step_in = step_ff + 1'b1;
               end else begin
                  rsp_kind_in = KIND_END;
                  rsp_word_in = '0;
                  rsp_last_in = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entries_ff  <= entries_in;
      hit_ff      <= hit_in;
      word_ff     <= word_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_entry_word = rsp_word_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire

[hw/rtl/mtf_checker.sv]
// Port-level checks of the word list responses, bound to the top level.
// Depends on mtf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mtf_checker
   import mtf_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [KIND_W-1:0] rsp_kind,
   input wire logic [WORD_W-1:0] rsp_entry_word,
   input wire logic              rsp_last
);

   logic is_ack;
   logic is_end;
   logic is_entry;
   logic closed_empty;

   assign is_ack       = rsp_valid && (rsp_kind == KIND_ACK);
   assign is_end       = rsp_valid && (rsp_kind == KIND_END);
   assign is_entry     = rsp_valid && (rsp_kind == KIND_ENTRY);
   assign closed_empty = rsp_last && (rsp_entry_word == '0);

   // Hold a stalled response beat.
   `MTF_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped")

   `MTF_ASSERT(a_ack_form, clock, reset, is_ack |-> closed_empty, "bad ack beat")

   `MTF_ASSERT(a_end_form, clock, reset, is_end |-> closed_empty, "bad end beat")

   // Stored words are never empty, and an entry never closes an item.
   `MTF_ASSERT(a_entry_form, clock, reset, is_entry |-> !rsp_last && (rsp_entry_word != '0), "bad entry beat")

   // Come out of reset with room for a request and no response pending.
   `MTF_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> req_ready && !rsp_valid, "not idle after reset")

endmodule

bind move_to_front_word_list mtf_checker u_checker (.*);

`default_nettype wire

[test/tb.sv]
// Self-checking testbench for move_to_front_word_list: drives add and list beats,
// keeps its own recency list to predict every response beat, and compares them in order.
// Depends on mtf_pkg and the move_to_front_word_list RTL.

module tb;
   import mtf_pkg::*;

   localparam int MAX_WORDS    = 5;
   localparam int WORD_BYTES   = 8;
   localparam int VOCAB_SIZE   = 8;
   localparam int HOLD_OFF_LEN = 80;
   localparam int DRAIN_CYCLES = 12;
   localparam int MAX_REPORTS  = 10;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [WORD_W-1:0] word;
      logic              last;
   } rsp_beat_type;

   // DUT ports; every input starts at a known value
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_op = OP_ADD;
   logic [WORD_W-1:0] req_word_key = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [KIND_W-1:0] rsp_kind;
   logic [WORD_W-1:0] rsp_entry_word;
   logic              rsp_last;

   // Shadow copy of the recency list, front first
   logic [WORD_W-1:0] shadow_words [MAX_WORDS];
   int                shadow_len = 0;

   // Response beats still owed by the DUT, oldest first
   rsp_beat_type awaited_beats [$];

   int unsigned error_count   = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   // Hold-off handshake: the test bumps the request count, the receiver
   // notices the change and counts the stall down on its own
   int unsigned hold_off_seq  = 0;
   int unsigned hold_off_seen = 0;
   int unsigned hold_off_left = 0;

   move_to_front_word_list #(
      .MAX_WORDS  (MAX_WORDS),
      .WORD_BYTES (WORD_BYTES)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_word_key   (req_word_key),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_entry_word (rsp_entry_word),
      .rsp_last       (rsp_last)
   );

   always #5 clock = ~clock;

   // Count a failure; print only the first few in detail
   function automatic void report_error(string msg);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("ERROR @%0t: %s", $time, msg);
   endfunction

   function automatic void expect_beat(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] word,
                                       logic last);
      rsp_beat_type b;
      b.kind = kind;
      b.word = word;
      b.last = last;
      awaited_beats.push_back(b);
   endfunction

   // Cut the key at its first zero byte, like a C string, keeping WORD_BYTES bytes
   function automatic logic [WORD_W-1:0] trim_key(logic [WORD_W-1:0] key);
      logic [WORD_W-1:0] w;
      bit                stop;
      w    = '0;
      stop = 1'b0;
      for (int b = 0; b < WORD_BYTES && b < 8; b++) begin
         if (key[8*b +: 8] == 8'h00)
            stop = 1'b1;
         if (!stop)
            w[8*b +: 8] = key[8*b +: 8];
      end
      return w;
   endfunction

   // Apply one accepted beat to the shadow list and queue the response beats it owes
   function automatic void predict_list_beats(logic op, logic [WORD_W-1:0] key);
      logic [WORD_W-1:0] word;
      int                hit;
      int                shift_from;
      if (op == OP_ADD) begin
         word = trim_key(key);
         if (word != '0) begin
            hit = -1;
            for (int i = 0; i < shadow_len; i++)
               if (hit < 0 && shadow_words[i] == word)
                  hit = i;
            // on a miss with a full list the back entry falls off
            if (hit >= 0)
               shift_from = hit;
            else if (shadow_len < MAX_WORDS)
               shift_from = shadow_len;
            else
               shift_from = MAX_WORDS - 1;
            for (int i = shift_from; i > 0; i--)
               shadow_words[i] = shadow_words[i-1];
            shadow_words[0] = word;
            if (hit < 0 && shadow_len < MAX_WORDS)
               shadow_len++;
         end
         expect_beat(KIND_ACK, '0, 1'b1);
      end else begin
         for (int i = 0; i < shadow_len; i++)
            expect_beat(KIND_ENTRY, shadow_words[i], 1'b0);
         expect_beat(KIND_END, '0, 1'b1);
      end
   endfunction

   function automatic void check_rsp_beat();
      rsp_beat_type exp_b;
      if (awaited_beats.size() == 0) begin
         report_error($sformatf("unexpected beat kind=%0d word=%h last=%0d",
                                rsp_kind, rsp_entry_word, rsp_last));
         return;
      end
      exp_b = awaited_beats.pop_front();
      if (rsp_kind !== exp_b.kind)
         report_error($sformatf("kind: expected %0d, got %0d", exp_b.kind, rsp_kind));
      if (rsp_entry_word !== exp_b.word)
         report_error($sformatf("entry_word: expected %h, got %h",
                                exp_b.word, rsp_entry_word));
      if (rsp_last !== exp_b.last)
         report_error($sformatf("last: expected %0d, got %0d", exp_b.last, rsp_last));
   endfunction

   // Monitor: sample both channels at the rising edge. Predict before checking
   // so a response in the same cycle as its request would still find its entry.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            predict_list_beats(req_op, req_word_key);
         if (rsp_valid && rsp_ready)
            check_rsp_beat();
      end
   end

   // Receiver: drop ready at random, or hold it low for a counted stretch on request
   always @(negedge clock) begin
      if (hold_off_seen != hold_off_seq) begin
         hold_off_seen = hold_off_seq;
         hold_off_left = HOLD_OFF_LEN;
      end
      if (hold_off_left != 0) begin
         hold_off_left = hold_off_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offer one request beat; call and return at a falling edge. Valid is only
   // lowered while idling, so back-to-back beats keep it high.
   task automatic send_item(input logic op, input logic [WORD_W-1:0] key);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_word_key <= key;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Stop offering, wait for every owed beat, then let the pipeline settle
   task automatic finish_phase();
      req_valid <= 1'b0;
      while (awaited_beats.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Word of 1..WORD_BYTES nonzero bytes, zero padded
   function automatic logic [WORD_W-1:0] random_word();
      logic [WORD_W-1:0] w;
      int unsigned       len;
      w   = '0;
      len = $urandom_range(1, WORD_BYTES);
      for (int b = 0; b < len; b++)
         w[8*b +: 8] = 8'($urandom_range(1, 255));
      return w;
   endfunction

   // Half the time, fill the bytes past the terminator with junk the DUT must ignore
   function automatic logic [WORD_W-1:0] junk_tail(logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] k;
      int unsigned       len;
      k   = w;
      len = 0;
      while (len < 8 && w[8*len +: 8] != 8'h00)
         len++;
      if (len < 7 && $urandom_range(1) == 1)
         for (int b = len + 1; b < 8; b++)
            k[8*b +: 8] = 8'($urandom);
      return k;
   endfunction

   // Corner cases: empty list, empty words, junk after the terminator,
   // refresh at front, middle and back, eviction when full
   task automatic test_directed_cases();
      send_item(OP_LIST, 64'h0);                     // empty list: end beat only
      send_item(OP_ADD,  64'h0);                     // empty word
      send_item(OP_ADD,  64'hFFFF_FFFF_4443_4200);   // zero low byte: empty word
      send_item(OP_LIST, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(OP_ADD,  64'hFFFF_FFFF_FFFF_FFFF);   // full eight-byte word
      send_item(OP_ADD,  64'h0000_0000_0000_0041);
      send_item(OP_ADD,  64'hDEAD_BEEF_0000_0041);   // same word, refresh at front
      send_item(OP_ADD,  64'h0000_0000_0000_4241);
      send_item(OP_ADD,  64'h5555_0000_0043_4241);
      send_item(OP_ADD,  64'h0000_0000_4443_4241);   // list now full
      send_item(OP_LIST, 64'h0);
      send_item(OP_ADD,  64'h0000_0000_0000_0045);   // evict the eight-byte word
      send_item(OP_ADD,  64'h0000_0000_0000_0041);   // refresh at back
      send_item(OP_ADD,  64'h0000_0000_0043_4241);   // refresh in the middle
      send_item(OP_LIST, 64'h0);
      send_item(OP_ADD,  64'h8000_0000_0000_0001);   // trims to one byte, new word
      send_item(OP_ADD,  64'h0100_0000_0000_00FF);
      send_item(OP_ADD,  64'h0);                     // empty word on a full list
      send_item(OP_ADD,  64'h7F7F_7F7F_7F7F_7F7F);
      send_item(OP_LIST, 64'h0);
      finish_phase();
   endtask

   // Mostly adds from a small vocabulary so both hits and evictions happen,
   // with list beats, fully random keys and empty words mixed in
   task automatic test_random_traffic(input int unsigned n_items,
                                      input int unsigned send_pct,
                                      input int unsigned recv_pct);
      logic [WORD_W-1:0] vocab [VOCAB_SIZE];
      int unsigned       roll;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int v = 0; v < VOCAB_SIZE; v++)
         vocab[v] = random_word();
      repeat (n_items) begin
         roll = $urandom_range(99);
         if (roll < 25)
            send_item(OP_LIST, {$urandom, $urandom});
         else if (roll < 85)
            send_item(OP_ADD, junk_tail(vocab[$urandom_range(VOCAB_SIZE - 1)]));
         else if (roll < 95)
            send_item(OP_ADD, {$urandom, $urandom});
         else
            send_item(OP_ADD, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_FF00);
      end
      finish_phase();
   endtask

   // Hold the receiver off while the sender keeps offering back to back,
   // so the internal queue fills and the DUT must drop req_ready
   task automatic test_input_backpressure();
      logic [WORD_W-1:0] w;
      send_idle_pct = 0;
      hold_off_seq++;
      repeat (14) begin
         w = random_word();
         send_item(OP_ADD, w);
         send_item(OP_LIST, 64'h0);
      end
      finish_phase();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 30;
      recv_idle_pct = 56;
      test_directed_cases();
      test_random_traffic(85, 30, 56);
      test_input_backpressure();
      test_random_traffic(85, 56, 30);
      test_random_traffic(85, 0, 0);

      if (awaited_beats.size() != 0)
         report_error($sformatf("%0d beats never arrived", awaited_beats.size()));
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/mtf_pkg.sv
hw/rtl/mtf_front.sv
hw/rtl/mtf_back.sv
hw/rtl/move_to_front_word_list.sv
hw/rtl/mtf_checker.sv
test/tb.sv
